### src/npw_pkg.sv
package npw_pkg;

  localparam int MAX_NODE_COUNT = 64;
  localparam int DEFAULT_COUNT  = 4;

  localparam int COORD_W = 16;   // signed Q8.8
  localparam int DIST_W  = 17;   // unsigned Q9.8
  localparam int PROX_W  = 17;   // unsigned Q1.16, up to 1.0
  localparam int FRAC_W  = 16;
  localparam int SQ_W    = 33;   // dx^2 + dy^2
  localparam int OUT_IDX_W = 6;

  localparam logic signed [COORD_W-1:0] UNIT_RADIUS = 16'sd256;

  typedef enum logic [2:0] {
    REQ_CURSOR    = 3'd0,
    REQ_NODE_R    = 3'd1,
    REQ_NODE_KEEP = 3'd2,
    REQ_LOAD      = 3'd3,
    REQ_EVAL      = 3'd4,
    REQ_COUNT     = 3'd5
  } req_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RMW,
    S_P1_RD,
    S_P1_DX,
    S_P1_DY,
    S_P1_SQ,
    S_P1_DV,
    S_P1_WR,
    S_P2_RD,
    S_P2_ST,
    S_P2_WT,
    S_P2_OUT
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] r;
  } node_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [PROX_W-1:0] prox;
  } scr_t;

endpackage

### src/node_proximity_weights.sv
// Channel | handshake                   | payload
// --------+-----------------------------+---------------------------------------------
// in      | in_valid_i / in_stall_o     | req_type, node_index, pos_x, pos_y, radius, count
// out     | out_valid_o / out_stall_i   | out_index, distance, weight, last
//
// Passes: one request runs two passes over the live nodes. Pass one reads a node,
// squares dx and dy on one shared multiplier, takes the root and then the
// proximity divide, which it skips when the node does not lie inside its radius.
// Pass two divides each proximity by the sum, or gives a zero weight when the sum
// is zero. A radius-keeping set first runs a read-modify-write state. Each output
// may wait on out_stall_i. The root and the divider are iterative.
// Reset: node table reads as (0, 0, unit radius) until a slot is written (per-slot
// valid bits), cursor at 0, live count at the default. No clearing pass.
// Stalls: in_stall_o is high while a request is in work; a held result does not
// stop the next request from updating state and running pass one.
module node_proximity_weights #(
  parameter int MAX_NODE_COUNT = npw_pkg::MAX_NODE_COUNT,
  parameter int DEFAULT_COUNT  = npw_pkg::DEFAULT_COUNT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [2:0]                         req_type_i,
  input  logic [5:0]                         node_index_i,
  input  logic signed [npw_pkg::COORD_W-1:0] pos_x_i,
  input  logic signed [npw_pkg::COORD_W-1:0] pos_y_i,
  input  logic signed [npw_pkg::COORD_W-1:0] node_radius_i,
  input  logic [6:0]                         new_count_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [npw_pkg::OUT_IDX_W-1:0]      out_index_o,
  output logic [npw_pkg::DIST_W-1:0]         distance_o,
  output logic [npw_pkg::PROX_W-1:0]         weight_o,
  output logic                               last_o
);

  localparam int IDX_W = (MAX_NODE_COUNT > 1) ? $clog2(MAX_NODE_COUNT) : 1;
  localparam int CNT_W = $clog2(MAX_NODE_COUNT + 1);
  localparam int TOT_W = npw_pkg::PROX_W + $clog2(MAX_NODE_COUNT);
  localparam int CNT_RST = (DEFAULT_COUNT > MAX_NODE_COUNT) ? MAX_NODE_COUNT :
                           ((DEFAULT_COUNT < 1) ? 1 : DEFAULT_COUNT);

  npw_pkg::state_e state_q, state_d;

  logic [IDX_W-1:0]                  node_q, node_d;
  logic [TOT_W-1:0]                  total_q, total_d;
  logic [CNT_W-1:0]                  live_q, live_d;
  logic signed [npw_pkg::COORD_W-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [2*npw_pkg::COORD_W-1:0]     sq_q, sq_d;
  logic [npw_pkg::PROX_W-1:0]        prox_q, prox_d, wt_q, wt_d;

  // Request fields kept for the radius-keeping read-modify-write
  logic signed [npw_pkg::COORD_W-1:0] upd_x_q, upd_y_q;
  logic [IDX_W-1:0]                   upd_idx_q;

  // Node table: one synchronous port pair, valid bit per slot
  npw_pkg::node_t    node_mem [MAX_NODE_COUNT];
  logic [MAX_NODE_COUNT-1:0] node_vld_q;
  npw_pkg::node_t    node_rd_q, node_wd, node_cur;
  logic              node_rd_vld_q;
  logic              node_we, node_re;
  logic [IDX_W-1:0]  node_wa, node_ra;

  // Per-node scratch between the two passes
  npw_pkg::scr_t     scr_mem [MAX_NODE_COUNT];
  npw_pkg::scr_t     scr_rd_q, scr_wd;
  logic              scr_we, scr_re;

  // Shared arithmetic
  logic [npw_pkg::COORD_W-1:0]       mul_a;
  logic [2*npw_pkg::COORD_W-1:0]     prod;
  logic signed [npw_pkg::COORD_W:0]  dx, dy;
  logic [npw_pkg::COORD_W-1:0]       adx, ady;
  logic                              sqrt_start, sqrt_done;
  logic [npw_pkg::SQ_W-1:0]          sqrt_in;
  logic [npw_pkg::DIST_W-1:0]        sqrt_root;
  logic                              div_start, div_done;
  logic [TOT_W-1:0]                  div_num, div_den;
  logic [npw_pkg::PROX_W-1:0]        div_quo;

  logic              out_load;
  logic              last_node;
  logic [CNT_W-1:0]  cnt_clamp;
  logic              idx_in_live, idx_in_cap;
  logic              in_xfer;

  assign in_stall_o = (state_q != npw_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign idx_in_live = 32'(node_index_i) < 32'(live_q);
  assign idx_in_cap  = 32'(node_index_i) < 32'(MAX_NODE_COUNT);
  assign last_node   = 32'(node_q) == (32'(live_q) - 32'd1);

  always_comb begin
    if (new_count_i == '0) begin
      cnt_clamp = CNT_W'(1);
    end else if (32'(new_count_i) > 32'(MAX_NODE_COUNT)) begin
      cnt_clamp = CNT_W'(MAX_NODE_COUNT);
    end else begin
      cnt_clamp = CNT_W'(new_count_i);
    end
  end

  // Slot never written reads as the reset node
  always_comb begin
    if (node_rd_vld_q) begin
      node_cur = node_rd_q;
    end else begin
      node_cur.x = '0;
      node_cur.y = '0;
      node_cur.r = npw_pkg::UNIT_RADIUS;
    end
  end

  assign dx  = {cur_x_q[npw_pkg::COORD_W-1], cur_x_q} -
               {node_cur.x[npw_pkg::COORD_W-1], node_cur.x};
  assign dy  = {cur_y_q[npw_pkg::COORD_W-1], cur_y_q} -
               {node_cur.y[npw_pkg::COORD_W-1], node_cur.y};
  assign adx = dx[npw_pkg::COORD_W] ? npw_pkg::COORD_W'(-dx) : dx[npw_pkg::COORD_W-1:0];
  assign ady = dy[npw_pkg::COORD_W] ? npw_pkg::COORD_W'(-dy) : dy[npw_pkg::COORD_W-1:0];

  assign mul_a   = (state_q == npw_pkg::S_P1_DX) ? adx : ady;
  assign prod    = mul_a * mul_a;
  assign sqrt_in = {1'b0, sq_q} + {1'b0, prod};

  npw_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_in),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  npw_div #(
    .DEN_W (TOT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d    = state_q;
    node_d     = node_q;
    total_d    = total_q;
    live_d     = live_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    sq_d       = sq_q;
    prox_d     = prox_q;
    wt_d       = wt_q;
    node_we    = 1'b0;
    node_re    = 1'b0;
    node_wa    = IDX_W'(node_index_i);
    node_ra    = node_q;
    node_wd.x  = pos_x_i;
    node_wd.y  = pos_y_i;
    node_wd.r  = node_radius_i;
    scr_we     = 1'b0;
    scr_re     = 1'b0;
    scr_wd.distance = sqrt_root;
    scr_wd.prox = prox_q;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    out_load   = 1'b0;

    unique case (state_q)
      npw_pkg::S_IDLE: begin
        if (in_xfer) begin
          node_d  = '0;
          total_d = '0;
          state_d = npw_pkg::S_P1_RD;
          unique case (npw_pkg::req_e'(req_type_i))
            npw_pkg::REQ_CURSOR: begin
              cur_x_d = pos_x_i;
              cur_y_d = pos_y_i;
            end
            npw_pkg::REQ_NODE_R: begin
              node_we = idx_in_live;
            end
            npw_pkg::REQ_NODE_KEEP: begin
              if (idx_in_live) begin
                node_re = 1'b1;
                node_ra = IDX_W'(node_index_i);
                state_d = npw_pkg::S_RMW;
              end
            end
            npw_pkg::REQ_LOAD: begin
              node_we = idx_in_cap;
            end
            npw_pkg::REQ_EVAL: begin
            end
            npw_pkg::REQ_COUNT: begin
              live_d = cnt_clamp;
            end
            default: begin
              state_d = npw_pkg::S_IDLE;
            end
          endcase
        end
      end
      npw_pkg::S_RMW: begin
        node_we   = 1'b1;
        node_wa   = upd_idx_q;
        node_wd.x = upd_x_q;
        node_wd.y = upd_y_q;
        node_wd.r = node_cur.r;
        state_d   = npw_pkg::S_P1_RD;
      end
      npw_pkg::S_P1_RD: begin
        node_re = 1'b1;
        state_d = npw_pkg::S_P1_DX;
      end
      npw_pkg::S_P1_DX: begin
        sq_d    = prod;
        state_d = npw_pkg::S_P1_DY;
      end
      npw_pkg::S_P1_DY: begin
        sqrt_start = 1'b1;
        state_d    = npw_pkg::S_P1_SQ;
      end
      npw_pkg::S_P1_SQ: begin
        if (sqrt_done) begin
          if ((node_cur.r > 0) &&
              (sqrt_root < npw_pkg::DIST_W'($unsigned(node_cur.r)))) begin
            div_start = 1'b1;
            div_num   = TOT_W'(npw_pkg::DIST_W'($unsigned(node_cur.r)) - sqrt_root);
            div_den   = TOT_W'($unsigned(node_cur.r));
            state_d   = npw_pkg::S_P1_DV;
          end else begin
            prox_d  = '0;
            state_d = npw_pkg::S_P1_WR;
          end
        end
      end
      npw_pkg::S_P1_DV: begin
        if (div_done) begin
          prox_d  = div_quo;
          state_d = npw_pkg::S_P1_WR;
        end
      end
      npw_pkg::S_P1_WR: begin
        scr_we  = 1'b1;
        total_d = total_q + TOT_W'(prox_q);
        if (last_node) begin
          node_d  = '0;
          state_d = npw_pkg::S_P2_RD;
        end else begin
          node_d  = node_q + IDX_W'(1);
          state_d = npw_pkg::S_P1_RD;
        end
      end
      npw_pkg::S_P2_RD: begin
        scr_re  = 1'b1;
        state_d = npw_pkg::S_P2_ST;
      end
      npw_pkg::S_P2_ST: begin
        if (total_q == '0) begin
          wt_d    = '0;
          state_d = npw_pkg::S_P2_OUT;
        end else begin
          div_start = 1'b1;
          div_num   = TOT_W'(scr_rd_q.prox);
          div_den   = total_q;
          state_d   = npw_pkg::S_P2_WT;
        end
      end
      npw_pkg::S_P2_WT: begin
        if (div_done) begin
          wt_d    = div_quo;
          state_d = npw_pkg::S_P2_OUT;
        end
      end
      npw_pkg::S_P2_OUT: begin
        if (!out_valid_o || !out_stall_i) begin
          out_load = 1'b1;
          if (last_node) begin
            state_d = npw_pkg::S_IDLE;
          end else begin
            node_d  = node_q + IDX_W'(1);
            state_d = npw_pkg::S_P2_RD;
          end
        end
      end
      default: begin
        state_d = npw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= npw_pkg::S_IDLE;
      node_q        <= '0;
      total_q       <= '0;
      live_q        <= CNT_W'(CNT_RST);
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      node_vld_q    <= '0;
      out_valid_o   <= 1'b0;
    end else begin
      state_q <= state_d;
      node_q  <= node_d;
      total_q <= total_d;
      live_q  <= live_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      if (node_we) begin
        node_vld_q[node_wa] <= 1'b1;
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    prox_q <= prox_d;
    wt_q   <= wt_d;
    if (in_xfer) begin
      upd_x_q   <= pos_x_i;
      upd_y_q   <= pos_y_i;
      upd_idx_q <= IDX_W'(node_index_i);
    end
    if (out_load) begin
      out_index_o <= npw_pkg::OUT_IDX_W'(node_q);
      distance_o  <= scr_rd_q.distance;
      weight_o    <= wt_q;
      last_o      <= last_node;
    end
  end

  // Node table; valid bit sampled with the read
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    if (node_re) begin
      node_rd_q     <= node_mem[node_ra];
      node_rd_vld_q <= node_vld_q[node_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (scr_we) begin
      scr_mem[node_q] <= scr_wd;
    end
    if (scr_re) begin
      scr_rd_q <= scr_mem[node_q];
    end
  end

  a_sqrt_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start |-> ##18 sqrt_done)
    else $error("root not done 18 cycles after start");

  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> ##17 div_done)
    else $error("quotient not done 17 cycles after start");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (weight_o <= 17'd65536))
    else $error("weight above 1.0");

  a_node_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(node_we && node_re))
    else $error("node table read and write in one cycle");

endmodule

### src/npw_isqrt.sv
// Bit-pair integer square root, one result bit per cycle.
module npw_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [npw_pkg::SQ_W-1:0]     rad_i,
  output logic                         done_o,
  output logic [npw_pkg::DIST_W-1:0]   root_o
);

  localparam int RES_W = npw_pkg::SQ_W + 1;

  logic                        busy_q;
  logic [npw_pkg::SQ_W-1:0]    v_q;
  logic [npw_pkg::SQ_W-1:0]    bit_q;
  logic [RES_W-1:0]            res_q;
  logic [RES_W-1:0]            trial;
  logic                        take;

  assign trial  = res_q + {1'b0, bit_q};
  assign take   = {1'b0, v_q} >= trial;
  assign done_o = busy_q && (bit_q == '0);
  assign root_o = res_q[npw_pkg::DIST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bit_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      bit_q  <= {1'b1, {(npw_pkg::SQ_W-1){1'b0}}};
    end else if (busy_q) begin
      if (bit_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        bit_q <= bit_q >> 2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= rad_i;
      res_q <= '0;
    end else if (busy_q && (bit_q != '0)) begin
      if (take) begin
        v_q   <= v_q - trial[npw_pkg::SQ_W-1:0];
        res_q <= (res_q >> 1) + {1'b0, bit_q};
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

endmodule

### src/npw_div.sv
// Restoring divider for (num << 16) / den with num <= den; 17-bit quotient.
module npw_div #(
  parameter int DEN_W = 23
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [DEN_W-1:0]             num_i,
  input  logic [DEN_W-1:0]             den_i,
  output logic                         done_o,
  output logic [npw_pkg::PROX_W-1:0]   quo_o
);

  localparam int CNT_W = $clog2(npw_pkg::FRAC_W + 1);

  logic                        busy_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [DEN_W-1:0]            rem_q;
  logic [DEN_W-1:0]            den_q;
  logic [npw_pkg::PROX_W-1:0]  quo_q;
  logic [DEN_W:0]              rem2;
  logic                        ge;

  assign rem2   = {rem_q, 1'b0};
  assign ge     = rem2 >= {1'b0, den_q};
  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(npw_pkg::FRAC_W);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      if (num_i >= den_i) begin
        rem_q <= num_i - den_i;
        quo_q <= npw_pkg::PROX_W'(1);
      end else begin
        rem_q <= num_i;
        quo_q <= '0;
      end
    end else if (busy_q && (cnt_q != '0)) begin
      if (ge) begin
        rem_q <= DEN_W'(rem2 - {1'b0, den_q});
      end else begin
        rem_q <= rem2[DEN_W-1:0];
      end
      quo_q <= {quo_q[npw_pkg::PROX_W-2:0], ge};
    end
  end

endmodule
